FILE: rtl/core/assert_macros.svh
// Assertion helpers; every user provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mcrs_pkg.sv
package mcrs_pkg;

  localparam int unsigned MaxData = 32;
  localparam logic [7:0] ExcFlag = 8'h80;
  localparam logic [7:0] ExcIllegalAddr = 8'h02;

  typedef enum logic [2:0] {
    MODE_RD_COILS    = 3'd0,
    MODE_RD_DISCRETE = 3'd1,
    MODE_RD_HOLDING  = 3'd2,
    MODE_RD_INPUT    = 3'd3,
    MODE_WR_COIL     = 3'd4,
    MODE_WR_REG      = 3'd5,
    MODE_WR_COILS    = 3'd6,
    MODE_WR_REGS     = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    KIND_HDR  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_EXC  = 2'd2,
    KIND_ACK  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_EXC,
    ST_ACK,
    ST_SWR,
    ST_MWR,
    ST_HDR,
    ST_RR_ADDR,
    ST_RR_EMIT,
    ST_RC_ADDR,
    ST_RC_TAKE,
    ST_RC_EMIT
  } state_e;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  slave_id;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [15:0] data_word;
    logic        last_beat;
  } req_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  reply_slave_id;
    logic [7:0]  func_code;
    logic [7:0]  byte_count;
    logic [7:0]  exception_code;
    logic [15:0] data_value;
    logic        data_is_word;
    logic [15:0] echo_address;
    logic [15:0] echo_quantity;
    logic        last;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic  capture;
    logic  clear_step;
    logic  load_ptr;
    logic  end_write;
    logic  set_drop;
    logic  clr_drop;
    logic  coil_wr;
    logic  reg_wr;
    logic  step;
    logic  coil_rd;
    logic  reg_rd;
    logic  take_bit;
    logic  clr_acc;
    logic  emit;
    kind_e emit_kind;
    logic  emit_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic  out_free;
    logic  clr_last;
    mode_e mode;
    logic  is_coil;
    logic  read_bad;
    logic  single_bad;
    logic  range_bad;
    logic  last_beat;
    logic  drop;
    logic  remain_zero;
    logic  remain_one;
    logic  bit_last;
    logic  qty_zero;
  } status_t;

  function automatic logic [7:0] func_of_mode(mode_e m);
    logic [7:0] fc;
    case (m)
      MODE_RD_COILS:    fc = 8'd1;
      MODE_RD_DISCRETE: fc = 8'd2;
      MODE_RD_HOLDING:  fc = 8'd3;
      MODE_RD_INPUT:    fc = 8'd4;
      MODE_WR_COIL:     fc = 8'd5;
      MODE_WR_REG:      fc = 8'd6;
      MODE_WR_COILS:    fc = 8'd15;
      MODE_WR_REGS:     fc = 8'd16;
      default:          fc = 8'd0;
    endcase
    return fc;
  endfunction

endpackage

FILE: rtl/core/modbus_coil_register_server_core.sv
// Channel  Dir  tdata                                     tuser      tlast
// s_axis   in   slave_id, start_address, quantity,        mode       last_beat
//               data_word
// m_axis   out  reply_slave_id, func_code, byte_count,    kind       last
//               exception_code, data_value, data_is_word,
//               echo_address, echo_quantity
//
// One request beat at a time; a beat is taken while the last result still waits.
// Register read: header, then read and emit per word. Coil read: header, read and take per
// coil, emit per byte. Single write: write, ack. Multi-write beat: drop, or up to 8 coils, ack.
// Coil store is one bit wide, so coil traffic is set by its single read/write port.
// After reset a clearing pass over max(COIL_COUNT, REG_COUNT) addresses zeroes both stores.
// A stalled m_axis holds its result; processing waits only when a new one is due.
`include "assert_macros.svh"

module modbus_coil_register_server_core #(
  parameter int COIL_COUNT = 256,
  parameter int REG_COUNT  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] slave_id, [23:8] start_address, [39:24] quantity, [55:40] data_word
  input  logic [55:0] s_axis_tdata,
  // [2:0] mode
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] reply_slave_id, [15:8] func_code, [23:16] byte_count,
  // [31:24] exception_code, [47:32] data_value, [48] data_is_word,
  // [64:49] echo_address, [80:65] echo_quantity, [87:81] zero
  output logic [87:0] m_axis_tdata,
  // [1:0] kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import mcrs_pkg::*;

  req_t    req;
  res_t    res;
  cmd_t    cmd;
  status_t status;

  assign req.mode          = mode_e'(s_axis_tuser);
  assign req.slave_id      = s_axis_tdata[7:0];
  assign req.start_address = s_axis_tdata[23:8];
  assign req.quantity      = s_axis_tdata[39:24];
  assign req.data_word     = s_axis_tdata[55:40];
  assign req.last_beat     = s_axis_tlast;

  mcrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mcrs_dp #(
    .COIL_COUNT (COIL_COUNT),
    .REG_COUNT  (REG_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {7'b0, res.echo_quantity, res.echo_address, res.data_is_word,
                         res.data_value, res.exception_code, res.byte_count,
                         res.func_code, res.reply_slave_id};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

  // a result is only loaded when the output slot is empty or draining
  `ASSERT_AT(a_emit_has_room, cmd.emit |-> status.out_free, "result loaded into full slot")
  // a failed write being dropped never coexists with a write in progress
  `ASSERT_AT(a_drop_excl, status.drop |-> status.remain_zero, "drop with beats pending")
  // nothing moves on either side during the clearing pass
  `ASSERT_AT(a_clear_quiet, cmd.clear_step |-> (!s_axis_tready && !m_axis_tvalid),
             "traffic during clearing pass")
  // a fresh beat is always decoded in the cycle after it is taken
  `ASSERT_NEXT(a_capture_decode, cmd.capture, !s_axis_tready && !cmd.emit,
               "capture not followed by decode")

endmodule

FILE: rtl/core/mcrs_ctrl.sv
module mcrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mcrs_pkg::status_t status_i,
  output mcrs_pkg::cmd_t    cmd_o
);
  import mcrs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status_i.mode)
          MODE_RD_COILS, MODE_RD_DISCRETE, MODE_RD_HOLDING, MODE_RD_INPUT: begin
            cmd_o.clr_drop = 1'b1;
            if (status_i.read_bad) begin
              cmd_o.end_write = 1'b1;
              state_d         = ST_EXC;
            end else begin
              cmd_o.load_ptr = 1'b1;
              state_d        = ST_HDR;
            end
          end
          MODE_WR_COIL, MODE_WR_REG: begin
            cmd_o.clr_drop  = 1'b1;
            cmd_o.end_write = 1'b1;
            if (status_i.single_bad) begin
              state_d = ST_EXC;
            end else begin
              cmd_o.load_ptr = 1'b1;
              state_d        = ST_SWR;
            end
          end
          default: begin
            if (status_i.drop) begin
              // swallow beats of a failed write until its final beat
              if (status_i.last_beat) cmd_o.clr_drop = 1'b1;
              state_d = ST_IDLE;
            end else if (status_i.remain_zero) begin
              if (status_i.range_bad) begin
                if (!status_i.last_beat) cmd_o.set_drop = 1'b1;
                state_d = ST_EXC;
              end else begin
                cmd_o.load_ptr = 1'b1;
                state_d        = ST_MWR;
              end
            end else begin
              cmd_o.clr_acc = 1'b1;
              state_d       = ST_MWR;
            end
          end
        endcase
      end
      ST_SWR: begin
        if (status_i.is_coil) cmd_o.coil_wr = 1'b1;
        else                  cmd_o.reg_wr  = 1'b1;
        state_d = ST_ACK;
      end
      ST_MWR: begin
        if (status_i.remain_zero) begin
          cmd_o.end_write = 1'b1;
          state_d         = ST_ACK;
        end else if (status_i.is_coil) begin
          cmd_o.coil_wr = 1'b1;
          cmd_o.step    = 1'b1;
          if (status_i.remain_one) begin
            cmd_o.end_write = 1'b1;
            state_d         = ST_ACK;
          end else if (status_i.bit_last) begin
            if (status_i.last_beat) begin
              cmd_o.end_write = 1'b1;
              state_d         = ST_ACK;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end else begin
          cmd_o.reg_wr = 1'b1;
          cmd_o.step   = 1'b1;
          if (status_i.remain_one || status_i.last_beat) begin
            cmd_o.end_write = 1'b1;
            state_d         = ST_ACK;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EXC: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_EXC;
          cmd_o.emit_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_ACK: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_ACK;
          cmd_o.emit_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_HDR: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_HDR;
          cmd_o.emit_last = status_i.qty_zero;
          if (status_i.qty_zero)     state_d = ST_IDLE;
          else if (status_i.is_coil) state_d = ST_RC_ADDR;
          else                       state_d = ST_RR_ADDR;
        end
      end
      ST_RR_ADDR: begin
        cmd_o.reg_rd = 1'b1;
        state_d      = ST_RR_EMIT;
      end
      ST_RR_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_DATA;
          cmd_o.emit_last = status_i.remain_one;
          cmd_o.step      = 1'b1;
          state_d         = status_i.remain_one ? ST_IDLE : ST_RR_ADDR;
        end
      end
      ST_RC_ADDR: begin
        cmd_o.coil_rd = 1'b1;
        state_d       = ST_RC_TAKE;
      end
      ST_RC_TAKE: begin
        cmd_o.take_bit = 1'b1;
        cmd_o.step     = 1'b1;
        if (status_i.remain_one || status_i.bit_last) state_d = ST_RC_EMIT;
        else                                          state_d = ST_RC_ADDR;
      end
      ST_RC_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_DATA;
          cmd_o.emit_last = status_i.remain_zero;
          cmd_o.clr_acc   = 1'b1;
          state_d         = status_i.remain_zero ? ST_IDLE : ST_RC_ADDR;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/mcrs_dp.sv
module mcrs_dp #(
  parameter int COIL_COUNT = 256,
  parameter int REG_COUNT  = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mcrs_pkg::req_t    req_i,
  input  mcrs_pkg::cmd_t    cmd_i,
  output mcrs_pkg::status_t status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mcrs_pkg::res_t    res_o
);
  import mcrs_pkg::*;

  localparam int CaW  = (COIL_COUNT > 1) ? $clog2(COIL_COUNT) : 1;
  localparam int RaW  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int ClrN = (COIL_COUNT > REG_COUNT) ? COIL_COUNT : REG_COUNT;
  localparam int ClW  = (ClrN > 1) ? $clog2(ClrN) : 1;
  localparam logic [ClW-1:0] ClrLast = ClW'(ClrN - 1);
  localparam logic [16:0] CoilLim = 17'(COIL_COUNT);
  localparam logic [16:0] RegLim  = 17'(REG_COUNT);
  localparam logic [15:0] CoilMaxQty = 16'(8 * MaxData);
  localparam logic [15:0] RegMaxQty  = 16'(MaxData);

  req_t            req_q;
  res_t            res_q, res_d;
  logic            out_valid_q, out_valid_d;
  logic [15:0]     ptr_q, ptr_d;
  logic [15:0]     remain_q, remain_d;
  logic [2:0]      bit_q, bit_d;
  logic [7:0]      acc_q, acc_d;
  logic            drop_q, drop_d;
  logic [ClW-1:0]  clr_q;

  logic            coil_mem [COIL_COUNT];
  logic [15:0]     reg_mem  [REG_COUNT];
  logic            coil_rd_q;
  logic [15:0]     reg_rd_q;

  logic            is_coil;
  logic [16:0]     size;
  logic [16:0]     end_addr;
  logic            range_bad, too_big, single_bad;
  logic [7:0]      nbytes;
  logic [16:0]     qty_round;
  logic [7:0]      fc;

  logic            coil_we, coil_wd, reg_we;
  logic [CaW-1:0]  coil_wa;
  logic [RaW-1:0]  reg_wa;
  logic [15:0]     reg_wd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
  end

  assign is_coil = (req_q.mode == MODE_RD_COILS) || (req_q.mode == MODE_RD_DISCRETE) ||
                   (req_q.mode == MODE_WR_COIL) || (req_q.mode == MODE_WR_COILS);
  assign size       = is_coil ? CoilLim : RegLim;
  assign end_addr   = {1'b0, req_q.start_address} + {1'b0, req_q.quantity};
  assign range_bad  = end_addr > size;
  assign single_bad = {1'b0, req_q.start_address} >= size;
  assign too_big    = is_coil ? (req_q.quantity > CoilMaxQty) : (req_q.quantity > RegMaxQty);
  assign qty_round  = ({1'b0, req_q.quantity} + 17'd7) >> 3;
  assign nbytes     = is_coil ? qty_round[7:0] : {req_q.quantity[6:0], 1'b0};
  assign fc         = func_of_mode(req_q.mode);

  // memory write ports: clearing pass or addressed write at the pointer
  always_comb begin
    if (cmd_i.clear_step) begin
      coil_we = 17'(clr_q) < CoilLim;
      coil_wa = clr_q[CaW-1:0];
      coil_wd = 1'b0;
      reg_we  = 17'(clr_q) < RegLim;
      reg_wa  = clr_q[RaW-1:0];
      reg_wd  = '0;
    end else begin
      coil_we = cmd_i.coil_wr && ({1'b0, ptr_q} < CoilLim);
      coil_wa = ptr_q[CaW-1:0];
      coil_wd = (req_q.mode == MODE_WR_COIL) ? (req_q.data_word != 16'd0)
                                             : req_q.data_word[{1'b0, bit_q}];
      reg_we  = cmd_i.reg_wr && ({1'b0, ptr_q} < RegLim);
      reg_wa  = ptr_q[RaW-1:0];
      reg_wd  = req_q.data_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (coil_we) coil_mem[coil_wa] <= coil_wd;
    if (cmd_i.coil_rd) coil_rd_q <= coil_mem[ptr_q[CaW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (reg_we) reg_mem[reg_wa] <= reg_wd;
    if (cmd_i.reg_rd) reg_rd_q <= reg_mem[ptr_q[RaW-1:0]];
  end

  always_comb begin
    ptr_d    = ptr_q;
    remain_d = remain_q;
    bit_d    = bit_q;
    acc_d    = acc_q;
    drop_d   = drop_q;
    if (cmd_i.load_ptr) begin
      ptr_d    = req_q.start_address;
      remain_d = req_q.quantity;
      bit_d    = '0;
      acc_d    = '0;
    end else begin
      if (cmd_i.take_bit) acc_d[bit_q] = coil_rd_q;
      if (cmd_i.step) begin
        ptr_d    = ptr_q + 16'd1;
        remain_d = remain_q - 16'd1;
        bit_d    = bit_q + 3'd1;
      end
      if (cmd_i.clr_acc) begin
        acc_d = '0;
        bit_d = '0;
      end
    end
    if (cmd_i.end_write) remain_d = '0;
    if (cmd_i.set_drop) drop_d = 1'b1;
    if (cmd_i.clr_drop) drop_d = 1'b0;
  end

  always_comb begin
    res_d                = '0;
    res_d.kind           = cmd_i.emit_kind;
    res_d.reply_slave_id = req_q.slave_id;
    res_d.func_code      = fc;
    res_d.last           = cmd_i.emit_last;
    case (cmd_i.emit_kind)
      KIND_HDR: res_d.byte_count = nbytes;
      KIND_DATA: begin
        res_d.data_value   = is_coil ? {8'h00, acc_q} : reg_rd_q;
        res_d.data_is_word = !is_coil;
      end
      KIND_EXC: begin
        res_d.func_code      = fc | ExcFlag;
        res_d.exception_code = ExcIllegalAddr;
      end
      KIND_ACK: begin
        res_d.echo_address  = req_q.start_address;
        res_d.echo_quantity = req_q.quantity;
      end
      default: res_d.kind = cmd_i.emit_kind;
    endcase
  end

  assign out_valid_d = cmd_i.emit ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ptr_q       <= '0;
      remain_q    <= '0;
      bit_q       <= '0;
      acc_q       <= '0;
      drop_q      <= 1'b0;
      clr_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      ptr_q       <= ptr_d;
      remain_q    <= remain_d;
      bit_q       <= bit_d;
      acc_q       <= acc_d;
      drop_q      <= drop_d;
      if (cmd_i.clear_step) clr_q <= clr_q + ClW'(1);
    end
  end

  assign status_o.out_free    = !out_valid_q || out_ready_i;
  assign status_o.clr_last    = clr_q == ClrLast;
  assign status_o.mode        = req_q.mode;
  assign status_o.is_coil     = is_coil;
  assign status_o.read_bad    = range_bad || too_big;
  assign status_o.single_bad  = single_bad;
  assign status_o.range_bad   = range_bad;
  assign status_o.last_beat   = req_q.last_beat;
  assign status_o.drop        = drop_q;
  assign status_o.remain_zero = remain_q == 16'd0;
  assign status_o.remain_one  = remain_q == 16'd1;
  assign status_o.bit_last    = bit_q == 3'd7;
  assign status_o.qty_zero    = req_q.quantity == 16'd0;

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule
